// File: hw/rtl/itoa_pkg.sv
// Shared constants and a helper function for the signed integer to decimal ASCII converter.
package itoa_pkg;

    localparam int MAX_DIGITS_DEF = 10;
    localparam int VALUE_W        = 32;
    localparam int CODE_W         = 6;
    localparam int DIGIT_W        = 4;
    localparam int CMP_W          = 36;

    localparam logic [CODE_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CODE_W-1:0] CHAR_MINUS = 6'd45;

    function automatic logic [CMP_W-1:0] pow10(input int exp);
        logic [CMP_W-1:0] acc;
        acc = CMP_W'(1);
        for (int i = 0; i < exp; i++)
        begin
            acc = acc * CMP_W'(10);
        end
        return acc;
    endfunction

endpackage

// File: hw/rtl/signed_int_to_decimal_ascii_top.sv
// Signed 32-bit integer to decimal ASCII character stream converter.
// Each accepted value leaves as 1 to MAX_DIGITS+1 characters on the char channel, one per
// cycle while char_ready is high: '-' first for negatives, then digits with leading zeros
// suppressed ('0' for zero); last_char marks the final character. Magnitudes above
// 10^MAX_DIGITS-1 saturate to all nines. The most negative value prints as -2147483648.
// A value passes through the input register, one register stage per digit position and the
// character register. A value holds the character register until its last character is
// taken; while the character register is draining, the digit pipeline holds its contents
// and accepts no new value.
module signed_int_to_decimal_ascii_top #(
    parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic signed [itoa_pkg::VALUE_W-1:0] value,
    output logic                                char_valid,
    input  logic                                char_ready,
    output logic        [itoa_pkg::CODE_W-1:0]  char_code,
    output logic                                last_char
);

    localparam int CW    = itoa_pkg::CMP_W;
    localparam int DW    = itoa_pkg::DIGIT_W;
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam logic [CW-1:0] LIMIT = itoa_pkg::pow10(MAX_DIGITS);

    typedef logic [MAX_DIGITS-1:0][DW-1:0] digits_t;

    logic            v_reg   [0:MAX_DIGITS];
    logic            neg_reg [0:MAX_DIGITS];
    logic [CW-1:0]   rem_reg [0:MAX_DIGITS];
    digits_t         dig_reg [0:MAX_DIGITS];

    logic            ser_valid_reg;
    logic            sign_reg;
    logic [IDX_W-1:0] idx_reg;
    digits_t         ser_dig_reg;

    logic            en;
    logic            neg_in;
    logic [CW-1:0]   mag_in;
    logic [CW-1:0]   sat_in;
    logic [IDX_W-1:0] lead;

    assign en         = !ser_valid_reg || (char_ready && last_char);
    assign item_ready = en;

    // input stage: magnitude and saturation
    always_comb
    begin
        neg_in = value[itoa_pkg::VALUE_W-1];
        mag_in = neg_in ? ((CW'(1) << itoa_pkg::VALUE_W) - CW'($unsigned(value)))
                        : CW'($unsigned(value));
        sat_in = (mag_in >= LIMIT) ? (LIMIT - CW'(1)) : mag_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= neg_in;
            rem_reg[0] <= sat_in;
            dig_reg[0] <= '0;
        end
    end

    // one digit position per stage, most significant first
    for (genvar s = 0; s < MAX_DIGITS; s++)
    begin : g_stage
        localparam int P = MAX_DIGITS - 1 - s;
        localparam logic [CW-1:0] POW = itoa_pkg::pow10(P);

        logic [DW-1:0] digit;
        logic [CW-1:0] sub;
        digits_t       dig_next;

        always_comb
        begin
            digit = '0;
            sub   = '0;
            for (int d = 1; d < 10; d++)
            begin
                if (rem_reg[s] >= CW'(d) * POW)
                begin
                    digit = DW'(d);
                    sub   = CW'(d) * POW;
                end
            end
            dig_next    = dig_reg[s];
            dig_next[P] = digit;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[s+1] <= neg_reg[s];
                rem_reg[s+1] <= rem_reg[s] - sub;
                dig_reg[s+1] <= dig_next;
            end
        end
    end

    // position of the leading nonzero digit, zero if none
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (dig_reg[MAX_DIGITS][i] != '0)
            begin
                lead = IDX_W'(i);
            end
        end
    end

    // character register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_valid_reg <= 1'b0;
            sign_reg      <= 1'b0;
            idx_reg       <= '0;
        end
        else if (en)
        begin
            ser_valid_reg <= v_reg[MAX_DIGITS];
            sign_reg      <= v_reg[MAX_DIGITS] && neg_reg[MAX_DIGITS];
            idx_reg       <= lead;
        end
        else if (char_ready)
        begin
            if (sign_reg)
            begin
                sign_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ser_dig_reg <= dig_reg[MAX_DIGITS];
        end
    end

    assign char_valid = ser_valid_reg;
    assign char_code  = sign_reg ? itoa_pkg::CHAR_MINUS
                                 : itoa_pkg::CHAR_ZERO
                                   + {{(itoa_pkg::CODE_W-DW){1'b0}}, ser_dig_reg[idx_reg]};
    assign last_char  = !sign_reg && (idx_reg == '0);

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the integer to decimal ASCII converter: table, then random values.
module tb_top;

    localparam int DIGITS      = itoa_pkg::MAX_DIGITS_DEF;
    localparam int RANDOM_ITEMS = 200;
    localparam int CALM_ITEMS   = 50;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 4 * (DIGITS + 2);
    localparam int TABLE_ROWS   = 24;

    typedef struct packed {
        logic [itoa_pkg::CODE_W-1:0] code;
        logic                        last;
    } char_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                item_valid = 1'b0;
    logic                                item_ready;
    logic signed [itoa_pkg::VALUE_W-1:0] value = '0;
    logic                                char_valid;
    logic                                char_ready = 1'b0;
    logic        [itoa_pkg::CODE_W-1:0]  char_code;
    logic                                last_char;

    char_t expected_chars[$];
    int    errors = 0;
    int    char_count = 0;
    bit    calm = 1'b0;
    bit    hold_req = 1'b0;

    // Rows with text are typed in; empty text means the predictor supplies it.
    logic signed [itoa_pkg::VALUE_W-1:0] table_value [TABLE_ROWS] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
        32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd2147483647, 32'sd1000000000,
        32'sd999999999, -32'sd999999999, -32'sd1000000000, 32'sd1000000,
        32'sd12345, -32'sd54321, 32'sh5555_5555, 32'shAAAA_AAAA,
        32'sd7, -32'sd9, 32'sd100000, 32'sd1999999999
    };
    string table_text [TABLE_ROWS] = '{
        "0", "1", "-1", "9", "10", "-10", "99", "100",
        "2147483647", "-2147483648", "-2147483647", "1000000000",
        "999999999", "-999999999", "-1000000000", "",
        "", "", "", "",
        "", "", "", ""
    };

    signed_int_to_decimal_ascii_top #(
        .MAX_DIGITS(DIGITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .value(value),
        .char_valid(char_valid),
        .char_ready(char_ready),
        .char_code(char_code),
        .last_char(last_char)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR t=%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void push_decimal_text(input logic [itoa_pkg::VALUE_W-1:0] raw);
        char_t           txt[$];
        char_t           c;
        longint unsigned mag;
        longint unsigned lim;
        longint unsigned div;
        longint unsigned dig;
        bit              started;
        int              i;
        started = 1'b0;
        lim = 1;
        for (i = 0; i < DIGITS; i++)
        begin
            lim = lim * 10;
        end
        mag = raw[itoa_pkg::VALUE_W-1] ? 64'h1_0000_0000 - 64'(raw) : 64'(raw);
        if (mag >= lim)
        begin
            mag = lim - 1;
        end
        if (raw[itoa_pkg::VALUE_W-1])
        begin
            c.code = itoa_pkg::CHAR_MINUS;
            c.last = 1'b0;
            txt.push_back(c);
        end
        for (div = lim / 10; div > 0; div = div / 10)
        begin
            dig = mag / div;
            if (dig != 0)
            begin
                started = 1'b1;
            end
            if (started || div == 1)
            begin
                c.code = itoa_pkg::CHAR_ZERO + itoa_pkg::CODE_W'(dig);
                c.last = 1'b0;
                txt.push_back(c);
            end
            mag = mag % div;
        end
        txt[txt.size()-1].last = 1'b1;
        expected_chars = {expected_chars, txt};
    endfunction

    function automatic void push_typed_text(input string s);
        char_t c;
        int    i;
        for (i = 0; i < s.len(); i++)
        begin
            c.code = itoa_pkg::CODE_W'(s[i]);
            c.last = (i == s.len() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    function automatic logic [itoa_pkg::VALUE_W-1:0] random_value();
        int                           pick;
        int                           d;
        longint unsigned              lim;
        logic [itoa_pkg::VALUE_W-1:0] mag;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h0000_0000;
                1: return 32'h8000_0000;
                2: return 32'h7FFF_FFFF;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        if (pick < 6)
        begin
            return $urandom;
        end
        d = $urandom_range(1, 9);
        lim = 1;
        repeat (d) lim = lim * 10;
        mag = itoa_pkg::VALUE_W'(64'($urandom) % lim);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Offer one value and hold it until the transfer; the caller decides on any gap.
    task automatic send_value(input logic [itoa_pkg::VALUE_W-1:0] v, input string text);
        item_valid <= 1'b1;
        value <= v;
        do @(posedge clk); while (!item_ready);
        if (text.len() != 0)
        begin
            push_typed_text(text);
        end
        else
        begin
            push_decimal_text(v);
        end
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && char_valid && char_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch($sformatf("char %0d: code %0d with nothing pending",
                                          char_count, char_code));
            end
            else
            begin
                if (char_code !== expected_chars[0].code)
                begin
                    report_mismatch($sformatf("char %0d: code %0d, expected %0d",
                                              char_count, char_code, expected_chars[0].code));
                end
                if (last_char !== expected_chars[0].last)
                begin
                    report_mismatch($sformatf("char %0d: last_char %0b, expected %0b",
                                              char_count, last_char, expected_chars[0].last));
                end
                void'(expected_chars.pop_front());
            end
            char_count++;
        end
    end

    initial
    begin
        @(posedge clk);
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                char_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                char_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                char_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                char_ready <= 1'b1;
            end
            else
            begin
                char_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int i;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < TABLE_ROWS; i++)
        begin
            send_value(table_value[i], table_text[i]);
            maybe_gap();
        end

        // Sender pause until the block has drained.
        item_valid <= 1'b0;
        do @(posedge clk); while (expected_chars.size() != 0);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 5)
            begin
                hold_req = 1'b1;
            end
            if (i == RANDOM_ITEMS - CALM_ITEMS)
            begin
                calm = 1'b1;
            end
            send_value(random_value(), "");
            if (i > 5 && i < 30)
            begin
                continue;
            end
            maybe_gap();
        end

        item_valid <= 1'b0;
        do @(posedge clk); while (expected_chars.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && expected_chars.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/itoa_pkg.sv
hw/rtl/signed_int_to_decimal_ascii_top.sv
bench/tb_top.sv
